FILE: rtl/hpr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hpr_pkg
// Shared constants for the histogram percentile range block.
// ---------------------------------------------------------------------------
package hpr_pkg;

  localparam int DEF_MAX_BINS   = 65536;
  localparam int DEF_COUNT_BITS = 32;

  localparam int DATA_W  = 32;   // Q16.16 sample width
  localparam int FRAC_W  = 17;   // Q1.16 fraction register width
  localparam int SCALE_W = 48;   // unsigned Q16.32 bin scale
  localparam int DIV_N_W = 64;   // divider dividend width
  localparam int DIV_D_W = 32;   // divider divisor width
  localparam int CFG_IDX_W = 1;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FRACTION  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRACTION = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/histogram_percentile_range.sv
`default_nettype none
// Range sample: the last one adds setup, a scale divide and a clear of the bins in use.
// Bin sample: three partial products form the bin index, then bin read and bin write.
// Final bin sample: a cumulative bin scan, up to two divides per percentile, then a clear
// of the bins in use; all bin accesses share one memory port.
// Reset is synchronous; no clearing pass follows reset, since bins are cleared
// at the end of every range pass.
// ---------------------------------------------------------------------------
// histogram_percentile_range
// Low/high percentile estimation of a Q16.16 sample set from a histogram.
// ---------------------------------------------------------------------------
module histogram_percentile_range
  import hpr_pkg::*;
#(
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAC_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic signed [DATA_W-1:0] in_sample,
  input  wire logic                 in_last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [DATA_W-1:0]  out_low_value,
  output logic signed [DATA_W-1:0]  out_high_value
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int N_W   = BIN_W + 1;
  localparam int ACC_W = DATA_W + SCALE_W;
  localparam int POS_W = 33;
  localparam int PRD_W = POS_W + DATA_W;
  localparam int THR_W = FRAC_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RSET, ST_SDIV, ST_CLEAR, ST_BMUL, ST_BRD, ST_BWR, ST_SSTART,
    ST_TH, ST_SCHK, ST_SADD, ST_FDIV, ST_MULA, ST_MULB, ST_ODIV, ST_FIN, ST_EMIT
  } state_t;

  state_t                     state_r;
  logic [FRAC_W-1:0]          lf_r, hf_r;
  logic signed [DATA_W-1:0]   low_r, high_r;
  logic [COUNT_BITS-1:0]      total_r, run_r, h_r;
  logic [N_W-1:0]             bins_r, k_r, clr_r;
  logic [SCALE_W-1:0]         scale_r;
  logic                       open_r, last_r, hi_phase_r;
  logic [DATA_W-1:0]          d_r;
  logic [ACC_W-1:0]           acc_r;
  logic [1:0]                 j_r;
  logic [BIN_W-1:0]           addr_r;
  logic [DIV_N_W-1:0]         cnt_r, thr_r, thr2_r;
  logic [POS_W-1:0]           pos_r;
  logic [PRD_W-1:0]           pacc_r;
  logic signed [DATA_W-1:0]   lo_val_r, val_r;
  logic                       out_valid_r;
  logic signed [DATA_W-1:0]   out_lo_r, out_hi_r;

  logic                       div_start_r;
  logic [DIV_N_W-1:0]         div_a_r;
  logic [DIV_D_W-1:0]         div_b_r;
  logic                       div_done;
  logic [DIV_N_W-1:0]         div_q;

  // bin memory
  logic [COUNT_BITS-1:0]      mem [MAX_BINS];
  logic [COUNT_BITS-1:0]      rd_r;
  logic                       mem_re, mem_we;
  logic [BIN_W-1:0]           mem_addr;
  logic [COUNT_BITS-1:0]      mem_wdata;

  // datapath helpers
  logic [DATA_W-1:0]          span_c;
  logic signed [DATA_W:0]     diff_c;
  logic [N_W-1:0]             top_c, n_c;
  logic [BIN_W-1:0]           idx_c;
  logic [SCALE_W-1:0]         idx_hi_c;
  logic [15:0]                chunk_c;
  logic [DATA_W+15:0]         part_c;
  logic [FRAC_W-1:0]          lf_c, hf_c;
  logic [THR_W-1:0]           t1_c, t2_c;
  logic [DIV_N_W-1:0]         cnt_sh_c, before_c, c1_c;
  logic                       below_c;
  logic [POS_W+15:0]          ppart_c;
  logic                       fire_in;

  assign fire_in  = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;

  assign span_c   = DATA_W'(high_r - low_r);
  assign diff_c   = DATA_W'(0) + ($signed({in_sample[DATA_W-1], in_sample})
                    - $signed({low_r[DATA_W-1], low_r}));
  assign top_c    = bins_r - 1'b1;
  assign n_c      = (64'(total_r) < 64'(MAX_BINS)) ? N_W'(total_r) : N_W'(MAX_BINS);

  // bin index from the accumulated product, limited to the top bin
  assign idx_hi_c = acc_r[ACC_W-1:32];
  assign idx_c    = (idx_hi_c > SCALE_W'(top_c)) ? top_c[BIN_W-1:0] : idx_hi_c[BIN_W-1:0];
  assign chunk_c  = scale_r[16*j_r +: 16];
  assign part_c   = d_r * chunk_c;

  // percentile thresholds in units of 2^-16 samples
  assign lf_c     = (lf_r > ONE_Q16) ? ONE_Q16 : lf_r;
  assign hf_c     = (hf_r > ONE_Q16) ? ONE_Q16 : hf_r;
  assign t1_c     = lf_c * total_r;
  assign t2_c     = hf_c * total_r;

  assign cnt_sh_c = cnt_r << 16;
  assign below_c  = cnt_sh_c < thr_r;
  assign before_c = (cnt_r - DIV_N_W'(h_r)) << 16;
  assign c1_c     = (thr_r > before_c) ? thr_r - before_c : '0;
  assign ppart_c  = pos_r * (j_r[0] ? span_c[31:16] : span_c[15:0]);

  // memory port selection
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = '0;
    case (state_r)
      ST_BRD: begin
        mem_re   = 1'b1;
        mem_addr = idx_c;
      end
      ST_BWR: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_r == COUNT_MAX) ? rd_r : rd_r + 1'b1;
      end
      ST_CLEAR: begin
        mem_we   = clr_r < bins_r;
        mem_addr = clr_r[BIN_W-1:0];
      end
      ST_SCHK: begin
        mem_re   = below_c && (k_r < bins_r);
        mem_addr = k_r[BIN_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_addr];
  end

  hpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lf_r        <= '0;
      hf_r        <= ONE_Q16;
      low_r       <= '0;
      high_r      <= '0;
      total_r     <= '0;
      run_r       <= '0;
      bins_r      <= '0;
      scale_r     <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_FRACTION:  lf_r <= cfg_wdata;
          REG_HIGH_FRACTION: hf_r <= cfg_wdata;
          default: ;
        endcase
      end

      // drop the result once taken
      if (out_valid_r && !out_stall && state_r != ST_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (fire_in) begin
            last_r <= in_last;
            if (!in_req_type) begin
              if (!open_r) begin
                low_r   <= in_sample;
                high_r  <= in_sample;
                total_r <= COUNT_BITS'(1);
                bins_r  <= '0;
                scale_r <= '0;
              end else begin
                if (in_sample < low_r)  low_r  <= in_sample;
                if (in_sample > high_r) high_r <= in_sample;
                if (total_r != COUNT_MAX) total_r <= total_r + 1'b1;
              end
              open_r <= !in_last;
              if (in_last) state_r <= ST_RSET;
            end else if (bins_r != '0 && run_r != COUNT_MAX) begin
              d_r     <= (diff_c > 0) ? diff_c[DATA_W-1:0] : '0;
              acc_r   <= '0;
              j_r     <= '0;
              state_r <= ST_BMUL;
            end else if (in_last) begin
              state_r <= ST_SSTART;
            end
          end
        end

        // set up histogram size and scale
        ST_RSET: begin
          bins_r  <= n_c;
          scale_r <= '0;
          clr_r   <= '0;
          if (span_c != '0 && n_c >= N_W'(2)) begin
            div_a_r     <= (DIV_N_W'(n_c - 1'b1) << 32) + DIV_N_W'(span_c) - 1'b1;
            div_b_r     <= span_c;
            div_start_r <= 1'b1;
            state_r     <= ST_SDIV;
          end else begin
            state_r <= ST_CLEAR;
          end
        end

        ST_SDIV: begin
          div_start_r <= 1'b0;
          if (div_done) begin
            scale_r <= div_q[SCALE_W-1:0];
            state_r <= ST_CLEAR;
          end
        end

        // sweep the bins in use to zero
        ST_CLEAR: begin
          run_r <= '0;
          if (clr_r < bins_r) begin
            clr_r <= clr_r + 1'b1;
          end else begin
            state_r <= ST_IDLE;
          end
        end

        // offset times scale, one 16-bit slice per cycle
        ST_BMUL: begin
          case (j_r)
            2'd0:    acc_r <= ACC_W'(part_c);
            2'd1:    acc_r <= acc_r + (ACC_W'(part_c) << 16);
            default: acc_r <= acc_r + (ACC_W'(part_c) << 32);
          endcase
          j_r <= j_r + 1'b1;
          if (j_r == 2'd2) state_r <= ST_BRD;
        end

        ST_BRD: begin
          addr_r  <= idx_c;
          state_r <= ST_BWR;
        end

        ST_BWR: begin
          run_r   <= run_r + 1'b1;
          state_r <= last_r ? ST_SSTART : ST_IDLE;
        end

        ST_SSTART: begin
          if (bins_r >= N_W'(2) && span_c != '0) begin
            state_r <= ST_TH;
          end else begin
            lo_val_r <= low_r;
            val_r    <= low_r;
            state_r  <= ST_EMIT;
          end
        end

        ST_TH: begin
          thr_r      <= DIV_N_W'(t1_c);
          thr2_r     <= (t2_c < t1_c) ? DIV_N_W'(t1_c) : DIV_N_W'(t2_c);
          k_r        <= '0;
          cnt_r      <= '0;
          hi_phase_r <= 1'b0;
          state_r    <= ST_SCHK;
        end

        // cumulative scan over the bins
        ST_SCHK: begin
          if (below_c && k_r < bins_r) begin
            state_r <= ST_SADD;
          end else if (below_c) begin
            val_r   <= high_r;
            state_r <= ST_FIN;
          end else if (k_r == '0) begin
            val_r   <= low_r;
            state_r <= ST_FIN;
          end else if (h_r == '0) begin
            pos_r   <= POS_W'(k_r - 1'b1) << 16;
            j_r     <= '0;
            state_r <= ST_MULA;
          end else begin
            div_a_r     <= c1_c;
            div_b_r     <= DIV_D_W'(h_r);
            div_start_r <= 1'b1;
            state_r     <= ST_FDIV;
          end
        end

        ST_SADD: begin
          cnt_r   <= cnt_r + DIV_N_W'(rd_r);
          h_r     <= rd_r;
          k_r     <= k_r + 1'b1;
          state_r <= ST_SCHK;
        end

        ST_FDIV: begin
          div_start_r <= 1'b0;
          if (div_done) begin
            pos_r   <= (POS_W'(k_r - 1'b1) << 16) + POS_W'(div_q[FRAC_W-1:0]);
            j_r     <= '0;
            state_r <= ST_MULA;
          end
        end

        // position times span in two slices
        ST_MULA: begin
          pacc_r  <= PRD_W'(ppart_c);
          j_r     <= 2'd1;
          state_r <= ST_MULB;
        end

        ST_MULB: begin
          div_a_r     <= DIV_N_W'((pacc_r + (PRD_W'(ppart_c) << 16)) >> 16);
          div_b_r     <= DIV_D_W'(top_c);
          div_start_r <= 1'b1;
          state_r     <= ST_ODIV;
        end

        // map back to the sample range, clamped
        ST_ODIV: begin
          div_start_r <= 1'b0;
          if (div_done) begin
            val_r   <= (div_q > DIV_N_W'(span_c)) ? high_r : low_r + $signed(div_q[DATA_W-1:0]);
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!hi_phase_r) begin
            lo_val_r   <= val_r;
            thr_r      <= thr2_r;
            hi_phase_r <= 1'b1;
            state_r    <= ST_SCHK;
          end else begin
            state_r <= ST_EMIT;
          end
        end

        // hold until the output register is free
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_lo_r    <= lo_val_r;
            out_hi_r    <= val_r;
            clr_r       <= '0;
            state_r     <= ST_CLEAR;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_value  = out_lo_r;
  assign out_high_value = out_hi_r;

`ifndef ASSERT_OFF
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= high_r)
    else $error("range minimum above maximum");

  a_bins_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bins_r <= N_W'(MAX_BINS))
    else $error("bins in use beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SADD |-> k_r < bins_r)
    else $error("scan past last bin");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside emit");
`endif

endmodule
`default_nettype wire

FILE: rtl/hpr_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hpr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hpr_div
  import hpr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_D_W-1:0] div_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic               done_r;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  // trial subtraction for one quotient bit
  assign rem_sh = {rem_r, quo_r[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        div_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_D_W'(rem_sh - {1'b0, div_r}) : rem_sh[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
